[design/kps_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad stopwatch package
// Shared widths, reset values, key codes and register indexes.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int DIGIT_W       = 4;
  localparam int SCAN_W        = 4;
  localparam int ROW_W         = 2;
  localparam int SPAN_W        = 6;
  localparam int PRESCALE_W    = 10;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 10;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 32;
  localparam int NUM_DIGITS_DEF = 4;

  localparam logic [SPAN_W-1:0]     PRESS_TICKS_RST = 6'd33;
  localparam logic [SPAN_W-1:0]     RELEASE_TICKS_RST = 6'd32;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 10'd1000;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic [SCAN_W-1:0] KEY_START = 4'd10;
  localparam logic [SCAN_W-1:0] KEY_PAUSE = 4'd11;
  localparam logic [SCAN_W-1:0] KEY_CLEAR = 4'd12;

  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE      = 2'd2;

  typedef struct packed {
    logic               title_shown;
    logic [SCAN_W-1:0]  last_key;
    logic               key_down;
    logic               buzzer_out;
    logic               running;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_ones;
    logic [ROW_W-1:0]   next_row;
  } result_t;

endpackage

[design/keypad_stopwatch_controller.sv]
// ----------------------------------------------------------------------------
// Keypad stopwatch controller
// One 4x4 keypad position is sampled per tick, presses and releases are
// debounced, keys 10, 11 and 12 start, pause and clear a decimal stopwatch.
// ----------------------------------------------------------------------------
// Each accepted tick item carries the four active-low return lines and yields
// exactly one result item: the item is held in an input register, then one
// pass of logic updates the scanner, debounce counters, buzzer, prescaler and
// digit carry chain and writes a two-entry result buffer. One item is accepted
// every clock cycle; the input side only stalls when both result buffer
// entries are waiting to be taken.
module keypad_stopwatch_controller #(
  parameter int NUM_DIGITS = kps_pkg::NUM_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Bits from lowest: return_lines[3:0], zero fill.
  input  logic [kps_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Bits from lowest: next_row[1:0], digit_ones[5:2], digit_tens[9:6],
  // digit_hundreds[13:10], digit_thousands[17:14], running[18],
  // buzzer_out[19], key_down[20], last_key[24:21], zero fill.
  output logic [kps_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Bits from lowest: title_shown[0].
  output logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic [kps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kps_pkg::*;

  logic [SPAN_W-1:0]     press_ticks;
  logic [SPAN_W-1:0]     release_ticks;
  logic [PRESCALE_W-1:0] tick_prescale;

  logic                  in_valid;
  logic [3:0]            in_lines;
  logic                  advance;

  logic [SCAN_W-1:0]     scan_pos, scan_pos_next;
  logic [SPAN_W-1:0]     press_count, press_count_next;
  logic [SPAN_W-1:0]     release_count, release_count_next;
  logic [SCAN_W-1:0]     captured_key, captured_key_next;
  logic                  key_held, key_held_next;
  logic                  buzz_enable, buzz_enable_next;
  logic                  buzz_level, buzz_level_next;
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic                  increment_due, increment_due_next;
  logic                  run_flag, run_flag_next;
  logic                  title_flag, title_flag_next;
  logic [DIGIT_W-1:0]    digits [NUM_DIGITS];
  logic [DIGIT_W-1:0]    digits_next [NUM_DIGITS];

  logic [SPAN_W-1:0]     press_span;
  logic [SPAN_W-1:0]     release_span;
  logic [PRESCALE_W-1:0] prescale_span;
  logic                  due_now;
  logic                  line_low;
  logic                  carry;

  logic [DIGIT_W-1:0]    shown [4];
  result_t               result;
  result_t               q_data [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            q_count;
  logic                  pop;

  assign press_span    = (press_ticks == '0) ? SPAN_W'(1) : press_ticks;
  assign release_span  = (release_ticks == '0) ? SPAN_W'(1) : release_ticks;
  assign prescale_span = (tick_prescale == '0) ? PRESCALE_W'(1) : tick_prescale;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks   <= PRESS_TICKS_RST;
      release_ticks <= RELEASE_TICKS_RST;
      tick_prescale <= PRESCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESS_TICKS:   press_ticks   <= cfg_data[SPAN_W-1:0];
        REG_RELEASE_TICKS: release_ticks <= cfg_data[SPAN_W-1:0];
        REG_PRESCALE:      tick_prescale <= cfg_data[PRESCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (q_count != 2'd2);
  assign s_tready = !in_valid || advance;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (q_count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_lines <= s_tdata[3:0];
    end
  end

  always_comb begin
    scan_pos_next       = scan_pos + SCAN_W'(1);
    press_count_next    = press_count;
    release_count_next  = release_count;
    captured_key_next   = captured_key;
    key_held_next       = key_held;
    buzz_enable_next    = buzz_enable;
    buzz_level_next     = buzz_level;
    prescale_count_next = prescale_count;
    run_flag_next       = run_flag;
    title_flag_next     = title_flag;
    increment_due_next  = 1'b0;
    due_now             = increment_due;
    carry               = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digits_next[i] = digits[i];
    end

    if (!increment_due) begin
      if (prescale_count <= PRESCALE_W'(1)) begin
        prescale_count_next = prescale_span;
        due_now             = 1'b1;
      end else begin
        prescale_count_next = prescale_count - PRESCALE_W'(1);
      end
    end

    if (buzz_enable) begin
      buzz_level_next = !buzz_level;
    end

    line_low = !in_lines[scan_pos[1:0]];
    if (!key_held) begin
      if (press_count == press_span) begin
        if (line_low) begin
          press_count_next  = press_count - SPAN_W'(1);
          captured_key_next = scan_pos;
        end
      end else if (press_count <= SPAN_W'(1)) begin
        press_count_next = press_span;
        if (line_low) begin
          key_held_next    = 1'b1;
          buzz_enable_next = 1'b1;
          if (captured_key == KEY_START) begin
            run_flag_next = 1'b1;
          end else if (captured_key == KEY_PAUSE) begin
            run_flag_next = 1'b0;
          end else if (captured_key == KEY_CLEAR) begin
            run_flag_next   = 1'b0;
            title_flag_next = 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
              digits_next[i] = '0;
            end
          end
        end
      end else begin
        press_count_next = press_count - SPAN_W'(1);
      end
    end else begin
      if (line_low) begin
        release_count_next = release_span;
      end else if (release_count <= SPAN_W'(1)) begin
        key_held_next      = 1'b0;
        buzz_enable_next   = 1'b0;
        release_count_next = release_span;
      end else begin
        release_count_next = release_count - SPAN_W'(1);
      end
    end

    if (due_now && run_flag_next) begin
      if (title_flag_next) begin
        title_flag_next = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          digits_next[i] = '0;
        end
      end else begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (carry) begin
            if (digits_next[i] >= DIGIT_MAX) begin
              digits_next[i] = '0;
            end else begin
              digits_next[i] = digits_next[i] + DIGIT_W'(1);
              carry          = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos       <= '0;
      press_count    <= PRESS_TICKS_RST;
      release_count  <= RELEASE_TICKS_RST;
      captured_key   <= '0;
      key_held       <= 1'b0;
      buzz_enable    <= 1'b0;
      buzz_level     <= 1'b1;
      prescale_count <= PRESCALE_RST;
      increment_due  <= 1'b1;
      run_flag       <= 1'b0;
      title_flag     <= 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (advance) begin
      scan_pos       <= scan_pos_next;
      press_count    <= press_count_next;
      release_count  <= release_count_next;
      captured_key   <= captured_key_next;
      key_held       <= key_held_next;
      buzz_enable    <= buzz_enable_next;
      buzz_level     <= buzz_level_next;
      prescale_count <= prescale_count_next;
      increment_due  <= increment_due_next;
      run_flag       <= run_flag_next;
      title_flag     <= title_flag_next;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= digits_next[i];
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_shown
    if (j < NUM_DIGITS) begin : g_used
      assign shown[j] = digits_next[j];
    end else begin : g_unused
      assign shown[j] = '0;
    end
  end

  always_comb begin
    result.title_shown     = title_flag_next;
    result.last_key        = captured_key_next;
    result.key_down        = key_held_next;
    result.buzzer_out      = buzz_level_next;
    result.running         = run_flag_next;
    result.digit_thousands = shown[3];
    result.digit_hundreds  = shown[2];
    result.digit_tens      = shown[1];
    result.digit_ones      = shown[0];
    result.next_row        = scan_pos_next[3:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (advance) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({advance, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q_data[wr_ptr] <= result;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(result_t) + 1){1'b0}},
                    q_data[rd_ptr][$bits(result_t)-2:0]};
  assign m_tuser = q_data[rd_ptr].title_shown;

endmodule

[design/kps_checker.sv]
// ----------------------------------------------------------------------------
// Keypad stopwatch port checker
// Watches the stream ports of the controller and is bound to its top level.
// ----------------------------------------------------------------------------
module kps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kps_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tuser
);
  import kps_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result stream is valid right after reset.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed or was dropped.");

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:2] <= DIGIT_MAX) && (m_tdata[9:6] <= DIGIT_MAX) &&
                 (m_tdata[13:10] <= DIGIT_MAX) && (m_tdata[17:14] <= DIGIT_MAX))
    else $error("A count digit is above nine.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalls although no result is waiting.");

endmodule

bind keypad_stopwatch_controller kps_checker u_kps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[verif/tb_keypad_stopwatch_controller.sv]
// ----------------------------------------------------------------------------
// Keypad stopwatch controller testbench
// Drives one keypad return-line sample per tick request and predicts every
// result with an in-bench model of the scanner, debounce counters, buzzer,
// prescaler and decimal count. Key holds are emulated as a real 4x4 keypad
// would answer the row scan, mixed with all-low holds, bounces and noise.
// Several debounce and prescale settings are used, including zero and the
// extremes. A run at the fastest prescale carries the count through its
// tens and hundreds digits.
// ----------------------------------------------------------------------------
module tb_keypad_stopwatch_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import kps_pkg::*;

  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int PHASE_TICKS    = 48;
  localparam int COUNT_TICKS    = 120;

  typedef struct packed {
    logic [ROW_W-1:0]   next_row;
    logic [DIGIT_W-1:0] ones;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] thousands;
    logic               running;
    logic               buzzer;
    logic               key_down;
    logic [SCAN_W-1:0]  last_key;
    logic [6:0]         fill;
    logic               title;
  } readout_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [SPAN_W-1:0]     cfg_press;
  logic [SPAN_W-1:0]     cfg_release;
  logic [PRESCALE_W-1:0] cfg_prescale;
  logic [SCAN_W-1:0]     scan_pos;
  logic [SPAN_W-1:0]     press_cnt;
  logic [SPAN_W-1:0]     release_cnt;
  logic [SCAN_W-1:0]     captured_key;
  logic                  held;
  logic                  buzz_en;
  logic                  buzz_lvl;
  logic [PRESCALE_W-1:0] prescale_cnt;
  logic                  incr_due;
  logic                  run;
  logic                  title;
  logic [DIGIT_W-1:0]    digits [4];

  readout_t readout_q [$];
  readout_t seen_readout;
  readout_t due_readout;

  bit idle_on;
  int stall_left;
  int ticks_sent;
  int readouts_checked;
  int mismatches;
  int presses_confirmed;
  int count_steps;

  keypad_stopwatch_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic reset_model();
    cfg_press    = PRESS_TICKS_RST;
    cfg_release  = RELEASE_TICKS_RST;
    cfg_prescale = PRESCALE_RST;
    scan_pos     = '0;
    press_cnt    = PRESS_TICKS_RST;
    release_cnt  = RELEASE_TICKS_RST;
    captured_key = '0;
    held         = 1'b0;
    buzz_en      = 1'b0;
    buzz_lvl     = 1'b1;
    prescale_cnt = PRESCALE_RST;
    incr_due     = 1'b1;
    run          = 1'b0;
    title        = 1'b1;
    digits       = '{default: '0};
  endtask

  task automatic predict_tick(input logic [3:0] lines, output readout_t r);
    logic [SPAN_W-1:0] press_span;
    logic [SPAN_W-1:0] rel_span;
    logic              line_low;
    logic              carry;
    press_span = (cfg_press == 0) ? SPAN_W'(1) : cfg_press;
    rel_span   = (cfg_release == 0) ? SPAN_W'(1) : cfg_release;

    if (!incr_due) begin
      if (prescale_cnt <= 1) begin
        prescale_cnt = (cfg_prescale == 0) ? PRESCALE_W'(1) : cfg_prescale;
        incr_due = 1'b1;
      end else begin
        prescale_cnt = prescale_cnt - 1'b1;
      end
    end

    if (buzz_en) buzz_lvl = ~buzz_lvl;

    line_low = ~lines[scan_pos[1:0]];
    if (!held) begin
      if (press_cnt == press_span) begin
        if (line_low) begin
          press_cnt    = press_cnt - 1'b1;
          captured_key = scan_pos;
        end
      end else if (press_cnt <= 1) begin
        press_cnt = press_span;
        if (line_low) begin
          held    = 1'b1;
          buzz_en = 1'b1;
          presses_confirmed++;
          case (captured_key)
            KEY_START: run = 1'b1;
            KEY_PAUSE: run = 1'b0;
            KEY_CLEAR: begin
              run    = 1'b0;
              digits = '{default: '0};
              title  = 1'b0;
            end
            default: ;
          endcase
        end
      end else begin
        press_cnt = press_cnt - 1'b1;
      end
    end else if (line_low) begin
      release_cnt = rel_span;
    end else if (release_cnt <= 1) begin
      held        = 1'b0;
      buzz_en     = 1'b0;
      release_cnt = rel_span;
    end else begin
      release_cnt = release_cnt - 1'b1;
    end
    scan_pos = scan_pos + 1'b1;

    if (incr_due) begin
      if (run) begin
        if (title) begin
          title  = 1'b0;
          digits = '{default: '0};
        end else begin
          carry = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (carry) begin
              if (digits[i] >= DIGIT_MAX) begin
                digits[i] = '0;
              end else begin
                digits[i] = digits[i] + 1'b1;
                carry = 1'b0;
              end
            end
          end
          count_steps++;
        end
      end
      incr_due = 1'b0;
    end

    r.next_row  = scan_pos[3:2];
    r.ones      = digits[0];
    r.tens      = digits[1];
    r.hundreds  = digits[2];
    r.thousands = digits[3];
    r.running   = run;
    r.buzzer    = buzz_lvl;
    r.key_down  = held;
    r.last_key  = captured_key;
    r.fill      = '0;
    r.title     = title;
  endtask

  // A held key pulls its return line low only while its own row is scanned.
  function automatic logic [3:0] keypad_lines(input logic [SCAN_W-1:0] key);
    if (scan_pos[3:2] == key[3:2]) return ~(4'b0001 << key[1:0]);
    return 4'hF;
  endfunction

  task automatic send_tick(input logic [3:0] lines);
    readout_t r;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(IN_DATA_W-4){1'b0}}, lines};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(lines, r);
    readout_q.push_back(r);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    s_tvalid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_PRESS_TICKS:   cfg_press    = val[SPAN_W-1:0];
      REG_RELEASE_TICKS: cfg_release  = val[SPAN_W-1:0];
      REG_PRESCALE:      cfg_prescale = val[PRESCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int press, input int release_span, input int prescale);
    wait_drained();
    write_reg(REG_PRESS_TICKS, CFG_DATA_W'(press));
    write_reg(REG_RELEASE_TICKS, CFG_DATA_W'(release_span));
    write_reg(REG_PRESCALE, CFG_DATA_W'(prescale));
  endtask

  // With the shortest spans a press is two low samples and a release one high.
  task automatic tap(input logic [SCAN_W-1:0] key);
    while (scan_pos != key) send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'hF);
  endtask

  task automatic test_key_actions();
    set_config(1, 1, 1);
    repeat (40) send_tick(4'hF);
    tap(SCAN_W'(5));
    tap(KEY_START);
    tap(KEY_PAUSE);
    tap(KEY_START);
    tap(KEY_CLEAR);
  endtask

  task automatic test_line_extremes();
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h5);
    send_tick(4'hA);
    send_tick(4'h3);
    send_tick(4'hC);
    send_tick(4'h0);
    send_tick(4'hF);
  endtask

  task automatic run_sequences(input int n_ticks);
    int          first;
    int          hold;
    int          gap;
    int          kind;
    int          press_span;
    int          rel_span;
    logic [3:0]  lines;
    logic [SCAN_W-1:0] key;
    first = ticks_sent;
    while (ticks_sent - first < n_ticks) begin
      press_span = (cfg_press == 0) ? 1 : cfg_press;
      rel_span   = (cfg_release == 0) ? 1 : cfg_release;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        if (kind < 6) begin
          key  = $urandom_range(0, 1) ? SCAN_W'(KEY_START + $urandom_range(0, 2))
                                      : SCAN_W'($urandom_range(0, 15));
          hold = 16 + press_span + $urandom_range(0, 24);
          for (int i = 0; i < hold; i++) begin
            lines = keypad_lines(key);
            if ($urandom_range(0, 30) == 0) lines[$urandom_range(0, 3)] = ~lines[0];
            send_tick(lines);
          end
        end else begin
          hold = $urandom_range(1, press_span + 6);
          repeat (hold) send_tick(4'h0);
        end
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rel_span)
                                          : rel_span + $urandom_range(0, 8);
        repeat (gap) send_tick(4'hF);
      end else begin
        repeat ($urandom_range(1, 12)) send_tick(4'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic test_random_traffic();
    int press;
    set_config(33, 32, $urandom_range(2, 30));
    idle_on = 1'b1;
    run_sequences(PHASE_TICKS / 2);
    wait_drained();
    run_sequences(PHASE_TICKS / 2);

    set_config(17, 20, 1);
    idle_on = 1'b0;
    run_sequences(PHASE_TICKS);

    set_config(63, 63, 1023);
    idle_on = 1'b1;
    run_sequences(PHASE_TICKS);

    set_config(0, 0, 0);
    run_sequences(PHASE_TICKS);

    case ($urandom_range(0, 3))
      0:       press = 17;
      1:       press = 33;
      2:       press = 49;
      default: press = $urandom_range(1, 63);
    endcase
    set_config(press, $urandom_range(1, 63), $urandom_range(1, 1023));
    idle_on = ($urandom_range(0, 1) == 1);
    run_sequences(PHASE_TICKS);
  endtask

  task automatic test_count_carry();
    set_config(1, 1, 1);
    idle_on = 1'b0;
    repeat (64) send_tick(4'hF);
    tap(KEY_CLEAR);
    tap(KEY_START);
    repeat (COUNT_TICKS) send_tick(4'hF);
    tap(KEY_PAUSE);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in result %0d, %s: expected %0d, got %0d",
                 readouts_checked, name, want, got);
    end
  endtask

  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
      m_tready = (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_readout.next_row  = m_tdata[1:0];
      seen_readout.ones      = m_tdata[5:2];
      seen_readout.tens      = m_tdata[9:6];
      seen_readout.hundreds  = m_tdata[13:10];
      seen_readout.thousands = m_tdata[17:14];
      seen_readout.running   = m_tdata[18];
      seen_readout.buzzer    = m_tdata[19];
      seen_readout.key_down  = m_tdata[20];
      seen_readout.last_key  = m_tdata[24:21];
      seen_readout.fill      = m_tdata[31:25];
      seen_readout.title     = m_tuser;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %0d arrived with none expected", readouts_checked);
      end else begin
        due_readout = readout_q.pop_front();
        check_field("next_row", due_readout.next_row, seen_readout.next_row);
        check_field("digit_ones", due_readout.ones, seen_readout.ones);
        check_field("digit_tens", due_readout.tens, seen_readout.tens);
        check_field("digit_hundreds", due_readout.hundreds, seen_readout.hundreds);
        check_field("digit_thousands", due_readout.thousands, seen_readout.thousands);
        check_field("running", due_readout.running, seen_readout.running);
        check_field("buzzer_out", due_readout.buzzer, seen_readout.buzzer);
        check_field("key_down", due_readout.key_down, seen_readout.key_down);
        check_field("last_key", due_readout.last_key, seen_readout.last_key);
        check_field("zero fill", due_readout.fill, seen_readout.fill);
        check_field("title_shown", due_readout.title, seen_readout.title);
      end
      readouts_checked++;
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Timeout with %0d results still expected", readout_q.size());
    $display("** keypad_stopwatch_controller: FAILED **");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_PRESS_TICKS;
    cfg_data  = '0;
    idle_on   = 1'b0;
    ticks_sent        = 0;
    readouts_checked  = 0;
    mismatches        = 0;
    presses_confirmed = 0;
    count_steps       = 0;
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_key_actions();
    test_line_extremes();
    test_random_traffic();
    test_count_carry();

    wait_drained();
    mismatches += readout_q.size();
    $display("Sent %0d ticks over six debounce and prescale settings: %0d key presses",
             ticks_sent, presses_confirmed);
    $display("confirmed, %0d count steps, %0d results checked, %0d mismatches.",
             count_steps, readouts_checked, mismatches);
    if (mismatches == 0) begin
      $display("** keypad_stopwatch_controller: PASSED **");
    end else begin
      $display("** keypad_stopwatch_controller: FAILED **");
    end
    $finish;
  end

endmodule
